/* design/color_sobel_edge_detector_assert.svh */
// Assertion macros for the color Sobel edge detector.
`ifndef COLOR_SOBEL_EDGE_DETECTOR_ASSERT_SVH
`define COLOR_SOBEL_EDGE_DETECTOR_ASSERT_SVH

`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define CSED_ASSERT_ALWAYS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// A property that must hold in the clock after a condition was seen.
`define CSED_ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) else $error(msg);
`else
`define CSED_ASSERT_ALWAYS(label, clk, rstn, prop, msg)
`define CSED_ASSERT_NEXT(label, clk, rstn, cond, prop, msg)
`endif

`endif

/* design/csed_pkg.sv */
// Shared constants and types of the color Sobel edge detector.
package csed_pkg;

    localparam int CHAN_W       = 8;
    localparam int PIX_W        = 3 * CHAN_W;
    localparam int COL_OUT_W    = 10;
    localparam int ROW_W        = 12;
    localparam int EDGE_W       = 8;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int MAX_WIDTH_DEFAULT = 1024;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;
    localparam int QUEUE_DEPTH  = 4;
    localparam int EDGE_SAT     = 255;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_MAX_MODE     = 2'd2
    } cfg_index_t;

    // One configuration write as seen by the front and back parts.
    typedef struct packed {
        logic                  we;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    // Fill status of the queue between front and back.
    typedef struct packed {
        logic empty;
        logic full;
    } qstat_t;

endpackage

/* design/csed_queue.sv */
// Small first-in first-out queue between the front and the back part.
module csed_queue #(
    parameter int DW = 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_en,
    input  logic [DW-1:0]   wr_data,
    input  logic            rd_en,
    output logic [DW-1:0]   rd_data,
    output csed_pkg::qstat_t stat
);

    localparam int DEPTH = csed_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;
    logic          do_wr, do_rd;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == (PW+1)'(DEPTH));
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && !stat.empty;
    assign rd_data    = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + (PW+1)'(1);
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* design/csed_front.sv */
// Front part: frame geometry registers, position counters and border classification.
module csed_front #(
    parameter int MAX_WIDTH = csed_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  csed_pkg::cfg_wr_t         cfg,
    input  logic                      s_valid,
    input  logic [csed_pkg::PIX_W-1:0] s_pixel,
    input  logic                      q_ready,
    output logic                      q_push,
    output logic [csed_pkg::PIX_W + $clog2(MAX_WIDTH) + csed_pkg::COL_OUT_W
                  + csed_pkg::ROW_W : 0] q_data
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WUW  = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (WUW > csed_pkg::WIDTH_REG_W) ? WUW : csed_pkg::WIDTH_REG_W;
    localparam int HW   = csed_pkg::HEIGHT_REG_W;
    localparam int RW   = csed_pkg::ROW_W;

    logic [csed_pkg::WIDTH_REG_W-1:0] width_reg, width_next;
    logic [HW-1:0]                    height_reg, height_next;
    logic [CW-1:0]                    col_reg, col_next;
    logic [RW-1:0]                    row_reg, row_next;

    logic [CMPW-1:0] w_ext, w_use;
    logic [HW-1:0]   h_use;
    logic            col_last, row_last, emit;
    logic [CW-1:0]   col_m1;
    logic [RW-1:0]   row_m1;

    // Width and height in use are the registers clamped to the legal range.
    always_comb begin
        w_ext = CMPW'(width_reg);
        if (w_ext < CMPW'(3)) begin
            w_use = CMPW'(3);
        end else if (w_ext > CMPW'(MAX_WIDTH)) begin
            w_use = CMPW'(MAX_WIDTH);
        end else begin
            w_use = w_ext;
        end
        if (height_reg < HW'(3)) begin
            h_use = HW'(3);
        end else if (height_reg > HW'(csed_pkg::HEIGHT_LIMIT)) begin
            h_use = HW'(csed_pkg::HEIGHT_LIMIT);
        end else begin
            h_use = height_reg;
        end
    end

    assign col_last = (CMPW'(col_reg) == (w_use - CMPW'(1)));
    assign row_last = (HW'(row_reg) == (h_use - HW'(1)));
    assign emit     = (col_reg >= CW'(2)) && (row_reg >= RW'(2));
    assign col_m1   = col_reg - CW'(1);
    assign row_m1   = row_reg - RW'(1);
    assign q_push   = s_valid && q_ready;
    assign q_data   = {emit, row_m1, csed_pkg::COL_OUT_W'(col_m1), col_reg, s_pixel};

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (q_push) begin
            if (col_last) begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + RW'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
        if (cfg.we) begin
            case (cfg.addr)
                csed_pkg::CFG_IMAGE_WIDTH: begin
                    width_next = cfg.data[csed_pkg::WIDTH_REG_W-1:0];
                    col_next   = '0;
                    row_next   = '0;
                end
                csed_pkg::CFG_IMAGE_HEIGHT: begin
                    height_next = cfg.data[HW-1:0];
                    col_next    = '0;
                    row_next    = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= csed_pkg::WIDTH_REG_W'(csed_pkg::WIDTH_RESET);
            height_reg <= HW'(csed_pkg::HEIGHT_RESET);
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

endmodule

/* design/csed_back.sv */
// Back part: line memories, 3x3 window and the pipelined Sobel magnitude datapath.
module csed_back #(
    parameter int MAX_WIDTH = csed_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  csed_pkg::cfg_wr_t             cfg,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  logic [csed_pkg::PIX_W + $clog2(MAX_WIDTH) + csed_pkg::COL_OUT_W
                  + csed_pkg::ROW_W : 0]  q_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [csed_pkg::EDGE_W-1:0]   m_edge,
    output logic [csed_pkg::COL_OUT_W-1:0] m_col,
    output logic [csed_pkg::ROW_W-1:0]    m_row
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int PW  = csed_pkg::PIX_W;
    localparam int KW  = csed_pkg::CHAN_W;
    localparam int OCW = csed_pkg::COL_OUT_W;
    localparam int RW  = csed_pkg::ROW_W;
    localparam int SW  = KW + 2;   // one weighted column or row sum
    localparam int TW  = SW + 2;   // sum of three differences

    function automatic logic [SW-1:0] wsum(input logic [KW-1:0] x, input logic [KW-1:0] y,
                                           input logic [KW-1:0] z);
        wsum = SW'(x) + {1'b0, y, 1'b0} + SW'(z);
    endfunction

    function automatic logic [SW-1:0] adiff(input logic [SW-1:0] x, input logic [SW-1:0] y);
        adiff = (x > y) ? x - y : y - x;
    endfunction

    // Fields of a queued item.
    logic [PW-1:0]  q_pix;
    logic [CW-1:0]  q_addr;
    logic [OCW-1:0] q_ocol;
    logic [RW-1:0]  q_orow;
    logic           q_emit;
    assign {q_emit, q_orow, q_ocol, q_addr, q_pix} = q_data;

    logic en;
    logic mode_reg, mode_next;

    logic [PW-1:0] upper_mem [MAX_WIDTH];
    logic [PW-1:0] middle_mem [MAX_WIDTH];

    // Stage 1: line memory read data and the item itself.
    logic           v1_reg;
    logic [PW-1:0]  rdu_reg, rdm_reg, pix1_reg;
    logic [CW-1:0]  addr1_reg;
    logic [OCW-1:0] ocol1_reg;
    logic [RW-1:0]  orow1_reg;
    logic           emit1_reg;
    logic [PW-1:0]  win_reg [6];

    // Stage 2: weighted sums per channel.
    logic           v2_reg;
    logic [OCW-1:0] ocol2_reg;
    logic [RW-1:0]  orow2_reg;
    logic [SW-1:0]  left_reg [3], right_reg [3], top_reg [3], bot_reg [3];
    logic [SW-1:0]  left_next [3], right_next [3], top_next [3], bot_next [3];

    // Stage 3: direction totals.
    logic           v3_reg;
    logic [OCW-1:0] ocol3_reg;
    logic [RW-1:0]  orow3_reg;
    logic [TW-1:0]  sh_reg, sv_reg, sh_next, sv_next;

    // Stage 4: output register.
    logic                        mv_reg;
    logic [csed_pkg::EDGE_W-1:0] edge_reg, edge_next;
    logic [OCW-1:0]              ocol4_reg;
    logic [RW-1:0]               orow4_reg;
    logic [TW:0]                 pick;
    logic [TW-1:0]               half;

    assign en      = !mv_reg || m_ready;
    assign q_pop   = q_valid && en;
    assign m_valid = mv_reg;
    assign m_edge  = edge_reg;
    assign m_col   = ocol4_reg;
    assign m_row   = orow4_reg;

    always_comb begin
        mode_next = mode_reg;
        if (cfg.we) begin
            case (cfg.addr)
                csed_pkg::CFG_MAX_MODE: mode_next = cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    // The item in stage 1 writes back its column while the next one reads;
    // neighboring items sit in different columns unless a size write restarts the counters between them.
    always_ff @(posedge aclk) begin
        if (en) begin
            if (q_valid) begin
                rdu_reg <= upper_mem[q_addr];
                rdm_reg <= middle_mem[q_addr];
            end
            if (v1_reg) begin
                upper_mem[addr1_reg]  <= rdm_reg;
                middle_mem[addr1_reg] <= pix1_reg;
            end
        end
    end

    // Window columns: entries 0..2 hold the left column (top, middle, bottom),
    // entries 3..5 the center column. The right column is the stage 1 data.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            left_next[k]  = wsum(win_reg[0][KW*k +: KW], win_reg[1][KW*k +: KW],
                                 win_reg[2][KW*k +: KW]);
            right_next[k] = wsum(rdu_reg[KW*k +: KW], rdm_reg[KW*k +: KW],
                                 pix1_reg[KW*k +: KW]);
            top_next[k]   = wsum(win_reg[0][KW*k +: KW], win_reg[3][KW*k +: KW],
                                 rdu_reg[KW*k +: KW]);
            bot_next[k]   = wsum(win_reg[2][KW*k +: KW], win_reg[5][KW*k +: KW],
                                 pix1_reg[KW*k +: KW]);
        end
    end

    always_comb begin
        sh_next = '0;
        sv_next = '0;
        for (int k = 0; k < 3; k++) begin
            sh_next = sh_next + TW'(adiff(left_reg[k], right_reg[k]));
            sv_next = sv_next + TW'(adiff(top_reg[k], bot_reg[k]));
        end
    end

    always_comb begin
        if (mode_reg) begin
            pick = (sh_reg > sv_reg) ? {sh_reg, 1'b0} : {sv_reg, 1'b0};
        end else begin
            pick = (TW+1)'(sh_reg) + (TW+1)'(sv_reg);
        end
        // Both halvings fold into one shift of the doubled or summed value.
        half = pick[TW:1] >> 1;
        if (half > TW'(csed_pkg::EDGE_SAT)) begin
            edge_next = csed_pkg::EDGE_W'(csed_pkg::EDGE_SAT);
        end else begin
            edge_next = half[csed_pkg::EDGE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            mv_reg   <= 1'b0;
        end else begin
            mode_reg <= mode_next;
            if (en) begin
                v1_reg <= q_valid;
                v2_reg <= v1_reg && emit1_reg;
                v3_reg <= v2_reg;
                mv_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pix1_reg  <= q_pix;
            addr1_reg <= q_addr;
            ocol1_reg <= q_ocol;
            orow1_reg <= q_orow;
            emit1_reg <= q_emit;
            if (v1_reg) begin
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= rdu_reg;
                win_reg[4] <= rdm_reg;
                win_reg[5] <= pix1_reg;
            end
            ocol2_reg <= ocol1_reg;
            orow2_reg <= orow1_reg;
            for (int k = 0; k < 3; k++) begin
                left_reg[k]  <= left_next[k];
                right_reg[k] <= right_next[k];
                top_reg[k]   <= top_next[k];
                bot_reg[k]   <= bot_next[k];
            end
            ocol3_reg <= ocol2_reg;
            orow3_reg <= orow2_reg;
            sh_reg    <= sh_next;
            sv_reg    <= sv_next;
            ocol4_reg <= ocol3_reg;
            orow4_reg <= orow3_reg;
            edge_reg  <= edge_next;
        end
    end

endmodule

/* design/color_sobel_edge_detector.sv */
// Top level of the streaming color Sobel edge detector.
//
//   Channel  Direction  Handshake             Payload (lowest bit first)
//   s_       in         s_tvalid / s_tready   chan_a[7:0], chan_b[7:0], chan_c[7:0]
//   m_       out        m_tvalid / m_tready   edge_value[7:0], out_col[9:0], out_row[11:0]
//   cfg_     in         cfg_we                cfg_addr selects register, cfg_wdata value
//
// One pixel word is taken per clock while s_tready is high, and at most one result
// word leaves per clock. A taken pixel goes through the queue; its head is taken by
// the registered line memory read, then weighted sums, direction totals and the final
// scaling each take one stage up to the output register. Reset clears only control
// state; the line memories need no clearing pass. If a result word waits on a low
// m_tready, the back pipeline holds; the four-word queue keeps s_tready high until full.
`include "color_sobel_edge_detector_assert.svh"

module color_sobel_edge_detector #(
    parameter int MAX_WIDTH = csed_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration writes: index 0 image_width, 1 image_height, 2 max_mode.
    input  logic                            cfg_we,
    input  logic [csed_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [csed_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Pixel input.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [23:0]                     s_tdata,   // chan_a, chan_b, chan_c
    // Edge result output.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata    // edge_value, out_col, out_row, zero pad
);

    localparam int CW = $clog2(MAX_WIDTH);
    // Queue word: pixel, memory column, output column, output row, result flag.
    localparam int DW = csed_pkg::PIX_W + CW + csed_pkg::COL_OUT_W + csed_pkg::ROW_W + 1;

    csed_pkg::cfg_wr_t cfg;
    csed_pkg::qstat_t  qstat;

    logic          q_push;
    logic          q_pop;
    logic [DW-1:0] q_wdata;
    logic [DW-1:0] q_rdata;

    logic [csed_pkg::EDGE_W-1:0]    edge_value;
    logic [csed_pkg::COL_OUT_W-1:0] out_col;
    logic [csed_pkg::ROW_W-1:0]     out_row;

    assign cfg.we   = cfg_we;
    assign cfg.addr = cfg_addr;
    assign cfg.data = cfg_wdata;

    // The input side only waits when the queue is full.
    assign s_tready = !qstat.full;

    // The front counts positions and decides, before any pixel math, whether
    // the word closes a window whose center lies inside the frame border.
    csed_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_tvalid),
        .s_pixel (s_tdata),
        .q_ready (s_tready),
        .q_push  (q_push),
        .q_data  (q_wdata)
    );

    csed_queue #(
        .DW (DW)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .rd_en   (q_pop),
        .rd_data (q_rdata),
        .stat    (qstat)
    );

    // The back keeps the line memories and window and computes the magnitude.
    csed_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_valid (!qstat.empty),
        .q_pop   (q_pop),
        .q_data  (q_rdata),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_edge  (edge_value),
        .m_col   (out_col),
        .m_row   (out_row)
    );

    assign m_tdata = {2'b00, out_row, out_col, edge_value};

    // A result always belongs to an inner row, so its row is never zero.
    `CSED_ASSERT_ALWAYS(a_row_inner, aclk, aresetn, !m_tvalid || (m_tdata[29:18] != 12'd0), "result row on frame border")

    // While the output word is stalled the back must not take from the queue.
    `CSED_ASSERT_ALWAYS(a_stall_holds_queue, aclk, aresetn, !(m_tvalid && !m_tready && q_pop), "queue popped during output stall")

    // An empty queue with no word coming in stays empty.
    `CSED_ASSERT_NEXT(a_empty_stays, aclk, aresetn, qstat.empty && !(s_tvalid && s_tready), qstat.empty, "queue filled without input")

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the streaming color Sobel edge detector.
`timescale 1ns / 100ps

module testbench;
    import csed_pkg::*;

    // The block may still be working on border pixels, which give no word, after
    // the last expected word has left. Such pixels pass the four-word input queue and
    // the back pipeline, and this quiet time covers that with room to spare.
    localparam int QUIET_CYCLES  = 16;
    // Cycles to wait for outstanding edge words before they count as missing.
    localparam int DRAIN_LIMIT   = 2000;
    // Length of the one long output stall that backs the block up to its input.
    localparam int LONG_HOLD     = 300;
    // Watchdog. A correct run ends well before this limit.
    localparam int CYCLE_LIMIT   = 4_000_000;
    // Pixels in the randomized small-frame part.
    localparam int RANDOM_ITEMS  = 730;
    // Pixels sent with a width above the legal range.
    localparam int TAIL_ITEMS    = 100;
    // The register index that the block does not decode; writes there are dropped.
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_INDEX = 2'd3;
    localparam int DIRECTED_ROWS = 23;

    // One edge word as it leaves on m_tdata, lowest field in the lowest bits.
    typedef struct packed {
        logic [ROW_W-1:0]     row;
        logic [COL_OUT_W-1:0] col;
        logic [EDGE_W-1:0]    mag;
    } edge_word_t;

    // Picture content of one random phase.
    typedef enum logic [1:0] {
        TEX_NOISE,
        TEX_FLAT,
        TEX_RAMP,
        TEX_BINARY
    } texture_t;

    typedef enum logic {
        ROW_WRITE,
        ROW_PIXEL
    } row_kind_t;

    // One row of the directed table: either a register write or a pixel. Where the
    // result of a pixel is obvious from the picture, it is typed in as magnitude.
    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_ADDR_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
        logic [PIX_W-1:0]      px;
        logic                  typed;
        logic [EDGE_W-1:0]     magnitude;
    } step_t;

    // Two 3x3 frames. The first has a saturated right column in max mode, so the
    // horizontal sum is 3060 and the output clips at 255. The second has only
    // chan_b of the middle-right pixel at 10 in average mode: (20 + 0) / 2 / 2 = 5.
    // The second frame starts after the counters wrapped at the end of the first,
    // and a write to the spare index before the first shows that it is ignored.
    localparam step_t DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_WRITE, CFG_IMAGE_WIDTH,  13'd3,    24'h000000, 1'b0, 8'd0},
        '{ROW_WRITE, CFG_IMAGE_HEIGHT, 13'd3,    24'h000000, 1'b0, 8'd0},
        '{ROW_WRITE, CFG_MAX_MODE,     13'd1,    24'h000000, 1'b0, 8'd0},
        '{ROW_WRITE, CFG_SPARE_INDEX,  13'h1FFF, 24'h000000, 1'b0, 8'd0},
        '{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'h000000, 1'b0, 8'd0},
        '{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'h000000, 1'b0, 8'd0},
        '{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'hFFFFFF, 1'b0, 8'd0},
        '{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'h000000, 1'b0, 8'd0},
        '{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'h000000, 1'b0, 8'd0},
        '{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'hFFFFFF, 1'b0, 8'd0},
        '{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'h000000, 1'b0, 8'd0},
        '{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'h000000, 1'b0, 8'd0},
        '{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'hFFFFFF, 1'b1, 8'd255},
        '{ROW_WRITE, CFG_MAX_MODE,     13'd0,    24'h000000, 1'b0, 8'd0},
        '{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'h000000, 1'b0, 8'd0},
        '{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'h000000, 1'b0, 8'd0},
        '{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'h000000, 1'b0, 8'd0},
        '{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'h000000, 1'b0, 8'd0},
        '{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'h000000, 1'b0, 8'd0},
        '{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'h000A00, 1'b0, 8'd0},
        '{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'h000000, 1'b0, 8'd0},
        '{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'h000000, 1'b0, 8'd0},
        '{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'h000000, 1'b1, 8'd5}
    };

    // Every input of the block has a known value from time zero.
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata   = '0;    // chan_a, chan_b, chan_c
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [31:0]           m_tdata;           // edge_value, out_col, out_row, zero pad

    // Mirror of the block's registers and state, kept up to date by the stimulus.
    logic [WIDTH_REG_W-1:0]  width_reg  = WIDTH_REG_W'(WIDTH_RESET);
    logic [HEIGHT_REG_W-1:0] height_reg = HEIGHT_REG_W'(HEIGHT_RESET);
    bit                      max_sel    = 1'b0;
    bit [PIX_W-1:0]          line_upper [MAX_WIDTH_DEFAULT];
    bit [PIX_W-1:0]          line_mid   [MAX_WIDTH_DEFAULT];
    bit [PIX_W-1:0]          win        [6];
    int unsigned             col_pos    = 0;
    int unsigned             row_pos    = 0;

    // Edge words that the block owes us, oldest first.
    edge_word_t pending_edges [$];

    int unsigned fault_count   = 0;
    int unsigned pixels_sent   = 0;
    int unsigned hold_requests = 0;
    bit          flush_on      = 1'b0;

    color_sobel_edge_detector uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic int unsigned clamp(input int unsigned v, input int unsigned lo,
                                          input int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Window g is indexed row * 3 + column, top-left first. Per channel the
    // absolute horizontal and vertical differences are summed, then the mode picks
    // the larger sum or their floored mean, which is halved and clipped at 255.
    function automatic logic [EDGE_W-1:0] sobel_magnitude(input logic [8:0][PIX_W-1:0] g,
                                                          input bit take_max);
        int k, lft, rgt, top, bot, sh, sv, m;
        sh = 0;
        sv = 0;
        for (k = 0; k < 3; k++) begin
            lft = g[0][k*8 +: 8] + 2 * g[3][k*8 +: 8] + g[6][k*8 +: 8];
            rgt = g[2][k*8 +: 8] + 2 * g[5][k*8 +: 8] + g[8][k*8 +: 8];
            top = g[0][k*8 +: 8] + 2 * g[1][k*8 +: 8] + g[2][k*8 +: 8];
            bot = g[6][k*8 +: 8] + 2 * g[7][k*8 +: 8] + g[8][k*8 +: 8];
            sh += (lft > rgt) ? lft - rgt : rgt - lft;
            sv += (top > bot) ? top - bot : bot - top;
        end
        if (take_max) m = (sh > sv) ? sh : sv;
        else m = (sh + sv) >> 1;
        m = m >> 1;
        return (m > EDGE_SAT) ? EDGE_SAT[EDGE_W-1:0] : m[EDGE_W-1:0];
    endfunction

    // Advances the mirrored state by one accepted pixel. When the pixel completes
    // an interior window, the edge word for the window centre is queued.
    function automatic bit edge_from_pixel(input logic [PIX_W-1:0] px);
        int unsigned w, h, c, r;
        bit [PIX_W-1:0] up2, up1;
        logic [8:0][PIX_W-1:0] g;
        edge_word_t e;
        bit made;
        w = clamp(32'(width_reg), 3, MAX_WIDTH_DEFAULT);
        h = clamp(32'(height_reg), 3, HEIGHT_LIMIT);
        c = col_pos;
        r = row_pos;
        if (c >= w) c = 0;
        if (r >= h) r = 0;
        up2 = line_upper[c];
        up1 = line_mid[c];
        made = (c >= 2 && r >= 2);
        if (made) begin
            g = {px, win[5], win[2], up1, win[4], win[1], up2, win[3], win[0]};
            e.mag = sobel_magnitude(g, max_sel);
            e.col = COL_OUT_W'(c - 1);
            e.row = ROW_W'(r - 1);
            pending_edges.push_back(e);
        end
        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = up2;
        win[4] = up1;
        win[5] = px;
        line_upper[c] = up1;
        line_mid[c]   = px;
        if (c + 1 >= w) begin
            c = 0;
            r = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            c++;
        end
        col_pos = c;
        row_pos = r;
        return made;
    endfunction

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10) $display("%s", msg);
    endtask

    task automatic check_edge_word(input logic [31:0] word);
        edge_word_t got, want;
        got = word[29:0];
        if (pending_edges.size() == 0) begin
            note_fault($sformatf("unexpected edge word: value %0d col %0d row %0d",
                                 got.mag, got.col, got.row));
        end else begin
            want = pending_edges.pop_front();
            if (got.mag !== want.mag || got.col !== want.col || got.row !== want.row) begin
                note_fault($sformatf({"edge word mismatch: expected value %0d col %0d ",
                                      "row %0d, got value %0d col %0d row %0d"},
                                     want.mag, want.col, want.row,
                                     got.mag, got.col, got.row));
            end
        end
    endtask

    // A register write drives cfg_we high for a single clock, then drops it and idles so
    // that back-to-back writes never raise and lower cfg_we in the same step.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_IMAGE_WIDTH: begin
                width_reg = val[WIDTH_REG_W-1:0];
                col_pos   = 0;
                row_pos   = 0;
            end
            CFG_IMAGE_HEIGHT: begin
                height_reg = val[HEIGHT_REG_W-1:0];
                col_pos    = 0;
                row_pos    = 0;
            end
            CFG_MAX_MODE: max_sel = val[0];
            default: ;
        endcase
    endtask

    // Offers one pixel word after a random gap and returns at the clock edge where
    // it is taken. The caller is left at that edge, so the next call can keep
    // s_tvalid high without a glitch. Every fifth stretch of 64 pixels has no gaps.
    task automatic send_pixel(input logic [PIX_W-1:0] px, output bit made_result);
        int gap;
        if (((pixels_sent / 64) % 5) == 2) gap = 0;
        else gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        made_result = edge_from_pixel(px);
        pixels_sent++;
    endtask

    // Brings the block to rest before a register write or the end of the run. The
    // result side is held ready so that nothing is stuck behind a stall, every
    // owed word must arrive, and then border pixels get time to leave the pipeline.
    task automatic settle();
        int waited;
        s_tvalid <= 1'b0;
        flush_on = 1'b1;
        waited   = 0;
        while (pending_edges.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_edges.size() != 0) begin
            note_fault($sformatf("%0d edge words never arrived", pending_edges.size()));
            pending_edges.delete();
        end
        repeat (QUIET_CYCLES) @(posedge aclk);
        flush_on = 1'b0;
    endtask

    // Streams count pixels of one picture style. At pixel index pause_at the input
    // goes quiet until every owed edge word has come back.
    task automatic run_pixels(input int count, input int pause_at);
        texture_t tex;
        logic [2:0][7:0] base;
        int slope_c [3];
        int slope_r [3];
        logic [PIX_W-1:0] px;
        bit made;
        int k, n;
        tex = texture_t'($urandom_range(0, 3));
        for (k = 0; k < 3; k++) begin
            base[k]    = 8'($urandom_range(0, 249));
            slope_c[k] = $urandom_range(0, 24);
            slope_r[k] = $urandom_range(0, 24);
        end
        for (n = 0; n < count; n++) begin
            for (k = 0; k < 3; k++) begin
                case (tex)
                    TEX_FLAT:   px[k*8 +: 8] = base[k] + 8'($urandom_range(0, 6));
                    TEX_RAMP:   px[k*8 +: 8] = 8'(col_pos * slope_c[k] +
                                                  row_pos * slope_r[k] + base[k]);
                    TEX_BINARY: px[k*8 +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    default:    px[k*8 +: 8] = 8'($urandom);
                endcase
            end
            send_pixel(px, made);
            if (n == pause_at) begin
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (pending_edges.size() != 0);
            end
        end
    endtask

    // Widths are mostly small. Now and then a value below the legal range, or one
    // with bits above the 11-bit register that the block must drop.
    function automatic logic [CFG_DATA_W-1:0] pick_width();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return CFG_DATA_W'($urandom_range(0, 2));
        if (r == 1) return 13'h1800 | 13'($urandom_range(3, 9));
        return CFG_DATA_W'($urandom_range(3, 12));
    endfunction

    // Heights are mostly small. Now and then a value below the legal range, or the
    // largest register value, which saturates to 4096 rows.
    function automatic logic [CFG_DATA_W-1:0] pick_height();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return CFG_DATA_W'($urandom_range(0, 2));
        if (r == 1) return 13'h1FFF;
        return CFG_DATA_W'($urandom_range(3, 8));
    endfunction

    // Result side: checks each edge word it takes and varies m_tready. It stays
    // ready without gaps for one stretch in four, and stalls for a long, counted
    // stretch each time the stimulus asks for one.
    initial begin : result_side
        int unsigned hold_left, gap_left, seen_holds, rx_cycle;
        bit next_ready;
        hold_left  = 0;
        gap_left   = 0;
        seen_holds = 0;
        rx_cycle   = 0;
        forever begin
            @(posedge aclk);
            rx_cycle++;
            if (aresetn && m_tvalid && m_tready) check_edge_word(m_tdata);
            if (seen_holds != hold_requests) begin
                seen_holds = hold_requests;
                hold_left  = LONG_HOLD;
            end
            if (flush_on) begin
                next_ready = 1'b1;
            end else if (hold_left > 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                next_ready = 1'b0;
            end else begin
                next_ready = 1'b1;
                if (((rx_cycle / 400) % 4) != 1) gap_left = pick_gap();
            end
            m_tready <= next_ready;
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("[color_sobel_edge_detector] ERROR");
        $finish;
    end

    initial begin : stimulus
        int i, phase_no, random_items, count, pause_at;
        int unsigned w_use, h_use;
        bit made, hold_done, pause_done;
        edge_word_t last;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Directed part: walk the table. Typed rows replace the predicted
        // magnitude with the one read off the picture.
        for (i = 0; i < DIRECTED_ROWS; i++) begin
            if (DIRECTED[i].kind == ROW_WRITE) begin
                settle();
                write_reg(DIRECTED[i].reg_index, DIRECTED[i].reg_value);
            end else begin
                send_pixel(DIRECTED[i].px, made);
                if (DIRECTED[i].typed && made) begin
                    last     = pending_edges.pop_back();
                    last.mag = DIRECTED[i].magnitude;
                    pending_edges.push_back(last);
                end
            end
        end

        // Random part: small frames under changing settings. Most phases resize,
        // which restarts the frame; the rest only flip the mode mid-frame. About a
        // quarter of the phases stop partway into a frame.
        phase_no     = 0;
        random_items = 0;
        hold_done    = 1'b0;
        pause_done   = 1'b0;
        while (random_items < RANDOM_ITEMS) begin
            settle();
            if (phase_no == 0 || $urandom_range(0, 9) < 7) begin
                write_reg(CFG_IMAGE_WIDTH, pick_width());
                write_reg(CFG_IMAGE_HEIGHT, pick_height());
                if ($urandom_range(0, 1)) begin
                    write_reg(CFG_MAX_MODE, CFG_DATA_W'($urandom_range(0, 8191)));
                end
            end else begin
                write_reg(CFG_MAX_MODE, {12'($urandom_range(0, 4095)), ~max_sel});
            end
            if ($urandom_range(0, 7) == 0) begin
                write_reg(CFG_SPARE_INDEX, CFG_DATA_W'($urandom_range(0, 8191)));
            end

            w_use = clamp(32'(width_reg), 3, MAX_WIDTH_DEFAULT);
            h_use = clamp(32'(height_reg), 3, HEIGHT_LIMIT);
            if (w_use * h_use <= 120) count = w_use * h_use * $urandom_range(1, 3);
            else count = w_use * $urandom_range(3, 5);
            if ($urandom_range(0, 3) == 0) count += $urandom_range(1, 2 * w_use);
            if (count > RANDOM_ITEMS - random_items) count = RANDOM_ITEMS - random_items;

            // Once, after the long stall has been seen, the input waits mid-phase
            // for every owed word.
            pause_at = -1;
            if (hold_done && !pause_done && count >= 20) begin
                pause_at   = count / 2;
                pause_done = 1'b1;
            end
            // Once, the result side stalls long enough that the queue fills and
            // s_tready drops while pixels keep being offered.
            if (!hold_done && count >= 40) begin
                hold_requests++;
                hold_done = 1'b1;
            end
            run_pixels(count, pause_at);
            random_items += count;
            phase_no++;
        end

        // A width above the legal range must behave as 1024 columns, so no row
        // ends within these pixels and no word comes back.
        settle();
        write_reg(CFG_IMAGE_WIDTH, 13'd2047);
        run_pixels(TAIL_ITEMS, -1);

        settle();
        if (fault_count == 0) begin
            $display("[color_sobel_edge_detector] OK");
        end else begin
            $display("[color_sobel_edge_detector] ERROR");
        end
        $finish;
    end

endmodule
